### hdl/bfic_pkg.sv
// ---------------------------------------------------------------------------
// bfic_pkg: shared types and constants for the credit-tracked byte FIFO
// Command and result beat layouts, opcodes and default sizing.
// ---------------------------------------------------------------------------
package bfic_pkg;

	localparam int unsigned DEFAULT_RING_DEPTH = 1024;
	localparam int unsigned COUNT_W            = 11;
	localparam int unsigned BYTE_W             = 8;
	localparam int unsigned OPCODE_W           = 3;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_BATCH   = 3'd1,
		OP_POP     = 3'd2,
		OP_CONSUME = 3'd3,
		OP_RESET   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BYTE_W-1:0]   data_byte;
		logic [COUNT_W-1:0]  consume_count;
	} cmd_t;

	typedef struct packed {
		logic                ok;
		logic [BYTE_W-1:0]   read_byte;
		logic [COUNT_W-1:0]  inflight_count;
		logic [COUNT_W-1:0]  inflight_peak;
		logic [COUNT_W-1:0]  ring_fill;
		logic [COUNT_W-1:0]  ring_peak;
		logic                demand;
	} rsp_t;

endpackage

### hdl/bfic_ring_mem.sv
// ---------------------------------------------------------------------------
// bfic_ring_mem: byte ring storage
// One write port and one registered read port.
// ---------------------------------------------------------------------------
module bfic_ring_mem import bfic_pkg::*; #(
	parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH,
	localparam int unsigned AW = $clog2(RING_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [RING_DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/bfic_ctrl.sv
// ---------------------------------------------------------------------------
// bfic_ctrl: pointers, credit and occupancy counters, result register
// Decodes one command beat per cycle, drives the ring port, builds results.
// ---------------------------------------------------------------------------
module bfic_ctrl import bfic_pkg::*; #(
	parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH,
	localparam int unsigned AW = $clog2(RING_DEPTH),
	localparam int unsigned CW = $clog2(RING_DEPTH + 1),
	localparam int unsigned LW = (CW > COUNT_W) ? CW : COUNT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	input  logic               limit_we,
	input  logic [COUNT_W-1:0] limit_wdata,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [BYTE_W-1:0]  mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  logic [BYTE_W-1:0]  mem_rdata,
	output logic               done,
	output rsp_t               rsp
);

	localparam logic [LW-1:0] DEPTH_L = LW'(RING_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(RING_DEPTH - 1);

	logic [COUNT_W-1:0] limit_q;
	logic [AW-1:0]      rd_ptr_q, wr_ptr_q, rd_ptr_n, wr_ptr_n;
	logic [CW-1:0]      occ_q, occ_n, rpeak_q, rpeak_n;
	logic [CW-1:0]      credits_q, credits_n, ipeak_q, ipeak_n;
	logic [CW-1:0]      reserved;
	logic [LW-1:0]      eff_limit, cap;
	logic               ok_n, pop_ok_n;

	logic                done_s1, ok_s1, pop_ok_s1, demand_s1;
	logic [COUNT_W-1:0]  credits_s1, ipeak_s1, occ_s1, rpeak_s1;

	always_comb begin
		eff_limit = (LW'(limit_q) > DEPTH_L) ? DEPTH_L : LW'(limit_q);
		cap       = (cmd.opcode == OP_PUSH) ? DEPTH_L : eff_limit;
		reserved  = credits_q + CW'(1);

		rd_ptr_n  = rd_ptr_q;
		wr_ptr_n  = wr_ptr_q;
		occ_n     = occ_q;
		rpeak_n   = rpeak_q;
		credits_n = credits_q;
		ipeak_n   = ipeak_q;
		ok_n      = 1'b0;
		pop_ok_n  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;

		if (cmd_valid) begin
			unique case (cmd.opcode)
				OP_PUSH, OP_BATCH: begin
					if (LW'(credits_q) < cap) begin
						// the peak sees the reserved credit even if the ring is full
						if (reserved > ipeak_q) begin
							ipeak_n = reserved;
						end
						if (occ_q != DEPTH_C) begin
							credits_n = reserved;
							mem_we    = 1'b1;
							wr_ptr_n  = (wr_ptr_q == LAST_A) ? '0 : wr_ptr_q + AW'(1);
							occ_n     = occ_q + CW'(1);
							if (occ_n > rpeak_q) begin
								rpeak_n = occ_n;
							end
							ok_n = 1'b1;
						end
					end
				end
				OP_POP: begin
					if (occ_q != '0) begin
						mem_re   = 1'b1;
						rd_ptr_n = (rd_ptr_q == LAST_A) ? '0 : rd_ptr_q + AW'(1);
						occ_n    = occ_q - CW'(1);
						ok_n     = 1'b1;
						pop_ok_n = 1'b1;
					end
				end
				OP_CONSUME: begin
					if (LW'(cmd.consume_count) <= LW'(credits_q)) begin
						credits_n = CW'(LW'(credits_q) - LW'(cmd.consume_count));
						ok_n      = 1'b1;
					end
				end
				OP_RESET: begin
					rd_ptr_n  = '0;
					wr_ptr_n  = '0;
					occ_n     = '0;
					rpeak_n   = '0;
					credits_n = '0;
					ipeak_n   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_waddr = wr_ptr_q;
	assign mem_wdata = cmd.data_byte;
	assign mem_raddr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			occ_q     <= '0;
			rpeak_q   <= '0;
			credits_q <= '0;
			ipeak_q   <= '0;
			done_s1   <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			rd_ptr_q  <= rd_ptr_n;
			wr_ptr_q  <= wr_ptr_n;
			occ_q     <= occ_n;
			rpeak_q   <= rpeak_n;
			credits_q <= credits_n;
			ipeak_q   <= ipeak_n;
			done_s1   <= cmd_valid;
		end
	end

	// result fields are masked to the port width
	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			ok_s1      <= ok_n;
			pop_ok_s1  <= pop_ok_n;
			credits_s1 <= COUNT_W'(LW'(credits_n));
			ipeak_s1   <= COUNT_W'(LW'(ipeak_n));
			occ_s1     <= COUNT_W'(LW'(occ_n));
			rpeak_s1   <= COUNT_W'(LW'(rpeak_n));
			demand_s1  <= LW'(credits_n) < eff_limit;
		end
	end

	assign done               = done_s1;
	assign rsp.ok             = ok_s1;
	assign rsp.read_byte      = pop_ok_s1 ? mem_rdata : '0;
	assign rsp.inflight_count = credits_s1;
	assign rsp.inflight_peak  = ipeak_s1;
	assign rsp.ring_fill      = occ_s1;
	assign rsp.ring_peak      = rpeak_s1;
	assign rsp.demand         = demand_s1;

endmodule

### hdl/byte_fifo_with_inflight_credits.sv
// ---------------------------------------------------------------------------
// byte_fifo_with_inflight_credits: byte ring FIFO with in-flight credits
// Top level: command decode and counters around one byte ring memory.
// ---------------------------------------------------------------------------
// Usage:
//   Command beat: cmd is taken at a rising edge with start high and busy
//   low. busy stays low, so a command can be issued every cycle.
//   Opcodes: push, batch push (bounded by the logical limit), pop,
//   consume (retire credits) and a clear of all FIFO state.
//   Result beat: done pulses for one cycle, in the cycle after the
//   command edge, with rsp valid in that cycle. Throughput is one
//   command per cycle; read_byte comes from the single read port of the
//   ring memory, whose registered output feeds it directly.
//   The receiver cannot stall; every result must be taken when shown.
//   Configuration: limit_we with limit_wdata writes the logical limit,
//   effective at the next command. Values above RING_DEPTH saturate.
//   Reset (arst_n low): counters, pointers and peaks clear, the limit
//   returns to 1024, no result is pending. Ring contents are not cleared;
//   only bytes written since are ever popped.
// ---------------------------------------------------------------------------
module byte_fifo_with_inflight_credits import bfic_pkg::*; #(
	parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               done,
	output rsp_t               rsp,
	input  logic               limit_we,
	input  logic [COUNT_W-1:0] limit_wdata
);

	localparam int unsigned AW = $clog2(RING_DEPTH);

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;

	// one command per cycle, never held off
	assign busy = 1'b0;

	bfic_ctrl #(
		.RING_DEPTH (RING_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (start && !busy),
		.cmd         (cmd),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.done        (done),
		.rsp         (rsp)
	);

	bfic_ring_mem #(
		.RING_DEPTH (RING_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### hdl/bfic_checker.sv
// ---------------------------------------------------------------------------
// bfic_checker: port-level checks for the credit-tracked byte FIFO
// Result timing and result consistency, bound to the top level.
// ---------------------------------------------------------------------------
module bfic_checker import bfic_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t rsp
);

	// every accepted command gives its result beat in the next cycle
	a_cmd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("command without result beat");

	a_result_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without command");

	// a clear leaves every counter at zero and reports failure
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == OP_RESET |=>
		!rsp.ok && rsp.inflight_count == '0 && rsp.ring_fill == '0 &&
		rsp.inflight_peak == '0 && rsp.ring_peak == '0)
		else $error("clear left state behind");

	a_byte_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.ok |-> rsp.read_byte == '0)
		else $error("read byte on failed beat");

	a_peaks_cover: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.inflight_peak >= rsp.inflight_count &&
		rsp.ring_peak >= rsp.ring_fill)
		else $error("peak below current count");

endmodule

bind byte_fifo_with_inflight_credits bfic_checker u_bfic_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);
